// ===== hw/rtl/wspf_pkg.sv =====
// ----------------------------------------------------------------------------
// wspf_pkg
// Shared constants, codes and control structs of the windowed score peak finder.
// ----------------------------------------------------------------------------
package wspf_pkg;

  localparam int WINDOW  = 27;
  localparam int ROWS    = 512;

  localparam int SCORE_W = 16;
  localparam int KIND_W  = 2;
  localparam int START_W = 9;
  localparam int TOTAL_W = 21;

  // running sum holds up to WINDOW full-scale scores
  localparam int SUM_W   = $clog2(WINDOW * (2 ** SCORE_W - 1) + 1);
  // row counter must reach ROWS and compare against WINDOW-1
  localparam int ROW_W   = $clog2(((ROWS > WINDOW) ? ROWS : WINDOW) + 1);

  localparam int IN_DATA_W  = 2 * SCORE_W;
  localparam int OUT_BITS   = KIND_W + START_W + TOTAL_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_NONE = 2'd0;
  localparam kind_t KIND_A    = 2'd1;
  localparam kind_t KIND_B    = 2'd2;

  // per-row control to each lane
  typedef struct packed {
    logic take;   // row is counted: shift ring, update sum, capture window sum
    logic full;   // a whole window is present after this row
    logic clear;  // frame end: sum restarts at zero
  } lane_ctl_t;

  // per-row control from the lane stage to the merge stage
  typedef struct packed {
    logic             check;  // window sums of this row compete for best
    logic             last;   // report and clear after this row
    logic [ROW_W-1:0] start;  // first row of this window
  } merge_ctl_t;

endpackage

// ===== hw/rtl/wspf_lane.sv =====
// ----------------------------------------------------------------------------
// wspf_lane
// One score stream: delay line of WINDOW rows, running box sum and the
// registered window sum of the latest counted row.
// ----------------------------------------------------------------------------
module wspf_lane (
  input  logic                               clk,
  input  logic                               rst_n,
  input  wspf_pkg::lane_ctl_t                ctl,
  input  logic [wspf_pkg::SCORE_W-1:0]       score,
  output logic [wspf_pkg::SUM_W-1:0]         win_r
);

  logic [wspf_pkg::SCORE_W-1:0] taps_r   [wspf_pkg::WINDOW];
  logic [wspf_pkg::SCORE_W-1:0] taps_nxt [wspf_pkg::WINDOW];
  logic [wspf_pkg::SUM_W-1:0]   sum_r;
  logic [wspf_pkg::SUM_W-1:0]   sum_nxt;
  logic [wspf_pkg::SUM_W-1:0]   win_nxt;
  logic [wspf_pkg::SCORE_W-1:0] oldest;

  always_comb begin
    taps_nxt[0] = score;
    for (int i = 1; i < wspf_pkg::WINDOW; i++) begin
      taps_nxt[i] = taps_r[i-1];
    end
  end

  // first row of the current window, dropped once it has been scored
  assign oldest  = taps_nxt[wspf_pkg::WINDOW-1];
  assign win_nxt = sum_r + wspf_pkg::SUM_W'(score);

  always_comb begin
    sum_nxt = sum_r;
    if (ctl.clear) begin
      sum_nxt = '0;
    end else if (ctl.take) begin
      if (ctl.full) begin
        sum_nxt = win_nxt - wspf_pkg::SUM_W'(oldest);
      end else begin
        sum_nxt = win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      taps_r <= taps_nxt;
      win_r  <= win_nxt;
    end
  end

endmodule

// ===== hw/rtl/wspf_merge.sv =====
// ----------------------------------------------------------------------------
// wspf_merge
// Combines the lane window sums into the frame best (A first, then B) and
// holds the frame report in the output register.
// ----------------------------------------------------------------------------
module wspf_merge (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            s1_valid,
  input  wspf_pkg::merge_ctl_t            s1_ctl,
  input  logic [wspf_pkg::SUM_W-1:0]      win_a,
  input  logic [wspf_pkg::SUM_W-1:0]      win_b,
  output logic                            consume,
  output logic                            out_valid_r,
  input  logic                            out_ready,
  output wspf_pkg::kind_t                 out_kind_r,
  output logic [wspf_pkg::START_W-1:0]    out_start_r,
  output logic [wspf_pkg::TOTAL_W-1:0]    out_total_r
);

  wspf_pkg::kind_t                top_kind_r,  top_kind_nxt;
  logic [wspf_pkg::ROW_W-1:0]     top_start_r, top_start_nxt;
  logic [wspf_pkg::SUM_W-1:0]     top_total_r, top_total_nxt;
  wspf_pkg::kind_t                mid_kind,    cand_kind;
  logic [wspf_pkg::ROW_W-1:0]     mid_start,   cand_start;
  logic [wspf_pkg::SUM_W-1:0]     mid_total,   cand_total;
  logic                           out_valid_nxt;

  // a report waits only when the output slot is still occupied
  assign consume = s1_valid && (!s1_ctl.last || !out_valid_r || out_ready);

  always_comb begin
    mid_kind  = top_kind_r;
    mid_start = top_start_r;
    mid_total = top_total_r;
    if (s1_ctl.check && (win_a > top_total_r)) begin
      mid_kind  = wspf_pkg::KIND_A;
      mid_start = s1_ctl.start;
      mid_total = win_a;
    end
    cand_kind  = mid_kind;
    cand_start = mid_start;
    cand_total = mid_total;
    // B is tested against the best already updated by A
    if (s1_ctl.check && (win_b > mid_total)) begin
      cand_kind  = wspf_pkg::KIND_B;
      cand_start = s1_ctl.start;
      cand_total = win_b;
    end
  end

  always_comb begin
    top_kind_nxt  = top_kind_r;
    top_start_nxt = top_start_r;
    top_total_nxt = top_total_r;
    if (consume) begin
      if (s1_ctl.last) begin
        top_kind_nxt  = wspf_pkg::KIND_NONE;
        top_start_nxt = '0;
        top_total_nxt = '0;
      end else begin
        top_kind_nxt  = cand_kind;
        top_start_nxt = cand_start;
        top_total_nxt = cand_total;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (consume && s1_ctl.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_kind_r  <= wspf_pkg::KIND_NONE;
      top_start_r <= '0;
      top_total_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      top_kind_r  <= top_kind_nxt;
      top_start_r <= top_start_nxt;
      top_total_r <= top_total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && s1_ctl.last) begin
      out_kind_r  <= cand_kind;
      out_start_r <= cand_start[wspf_pkg::START_W-1:0];
      out_total_r <= cand_total[wspf_pkg::TOTAL_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/windowed_score_peak_finder.sv =====
// ----------------------------------------------------------------------------
// windowed_score_peak_finder
// Box sums of two score streams over the last WINDOW rows, best window per frame.
// ----------------------------------------------------------------------------
// Throughput: one row word per cycle, sustained, as long as reports are taken.
// A report follows the accepted frame_end word through the lane stage, then the
//   merge stage into the output register.
// A frame_end word that finds the report slot still full holds the input
//   until out_tready rises.
// Reset clears counters, sums, best and valids; the delay lines are not reset.
// ----------------------------------------------------------------------------
module windowed_score_peak_finder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [wspf_pkg::IN_DATA_W-1:0]      in_tdata,   // score_a, score_b
  input  logic                                in_tlast,   // frame_end
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [wspf_pkg::OUT_DATA_W-1:0]     out_tdata   // best_kind, best_start, best_total
);

  logic                              accept;
  logic                              take;
  logic                              full;
  logic [wspf_pkg::ROW_W-1:0]        row_count_r, row_count_nxt;
  logic                              s1_valid_r, s1_valid_nxt;
  wspf_pkg::merge_ctl_t              s1_ctl_r, s1_ctl_nxt;
  wspf_pkg::lane_ctl_t               lane_ctl;
  logic [wspf_pkg::SCORE_W-1:0]      score_a;
  logic [wspf_pkg::SCORE_W-1:0]      score_b;
  logic [wspf_pkg::SUM_W-1:0]        win_a;
  logic [wspf_pkg::SUM_W-1:0]        win_b;
  logic                              consume;
  wspf_pkg::kind_t                   best_kind;
  logic [wspf_pkg::START_W-1:0]      best_start;
  logic [wspf_pkg::TOTAL_W-1:0]      best_total;

  assign score_a = in_tdata[wspf_pkg::SCORE_W-1:0];
  assign score_b = in_tdata[2*wspf_pkg::SCORE_W-1:wspf_pkg::SCORE_W];

  assign in_tready = !s1_valid_r || consume;
  assign accept    = in_tvalid && in_tready;
  // rows past ROWS are dropped, frame_end still counts
  assign take      = accept && (row_count_r < wspf_pkg::ROW_W'(wspf_pkg::ROWS));
  assign full      = row_count_r >= wspf_pkg::ROW_W'(wspf_pkg::WINDOW - 1);

  assign lane_ctl.take  = take;
  assign lane_ctl.full  = full;
  assign lane_ctl.clear = accept && in_tlast;

  always_comb begin
    row_count_nxt = row_count_r;
    if (accept && in_tlast) begin
      row_count_nxt = '0;
    end else if (take) begin
      row_count_nxt = row_count_r + wspf_pkg::ROW_W'(1);
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_ctl_nxt   = s1_ctl_r;
    if (accept) begin
      s1_valid_nxt     = 1'b1;
      s1_ctl_nxt.check = take && full;
      s1_ctl_nxt.last  = in_tlast;
      s1_ctl_nxt.start = row_count_r - wspf_pkg::ROW_W'(wspf_pkg::WINDOW - 1);
    end else if (consume) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      row_count_r <= row_count_nxt;
      s1_valid_r  <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl_r <= s1_ctl_nxt;
  end

  wspf_lane u_lane_a (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (lane_ctl),
    .score (score_a),
    .win_r (win_a)
  );

  wspf_lane u_lane_b (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (lane_ctl),
    .score (score_b),
    .win_r (win_b)
  );

  wspf_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_valid    (s1_valid_r),
    .s1_ctl      (s1_ctl_r),
    .win_a       (win_a),
    .win_b       (win_b),
    .consume     (consume),
    .out_valid_r (out_tvalid),
    .out_ready   (out_tready),
    .out_kind_r  (best_kind),
    .out_start_r (best_start),
    .out_total_r (best_total)
  );

  assign out_tdata = wspf_pkg::OUT_DATA_W'({best_total, best_start, best_kind});

  // an empty report carries no window
  a_none_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (best_kind == wspf_pkg::KIND_NONE) |-> (best_total == '0) && (best_start == '0))
    else $error("kind none with nonzero start or total");

  // a winning window beat zero
  a_win_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (best_kind != wspf_pkg::KIND_NONE) |-> (best_total != '0))
    else $error("winning window with zero total");

  // row counter saturates at ROWS
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_count_r <= wspf_pkg::ROW_W'(wspf_pkg::ROWS))
    else $error("row counter past ROWS");

  // a frame end taken into an empty pipe with a free output is consumed by the merge stage, then reported
  a_report: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tlast && !out_tvalid && !s1_valid_r |=> consume ##1 out_tvalid)
    else $error("frame end without report");

endmodule

// ===== sim/wspf_report_checker.sv =====
// ----------------------------------------------------------------------------
// wspf_report_checker
// Predicts the per-frame peak report from the row words seen on the input and
// compares every report word taken on the output with the oldest prediction.
// ----------------------------------------------------------------------------
module wspf_report_checker
  import wspf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // score_a, score_b
  input  logic                  in_tlast,   // frame_end
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // best_kind, best_start, best_total
  output int                    mismatches,
  output int                    reports_due,
  output int                    reports_seen
);

  typedef struct packed {
    kind_t               kind;
    logic [START_W-1:0]  start;
    logic [TOTAL_W-1:0]  total;
  } peak_report_t;

  logic [SCORE_W-1:0] hist_a [WINDOW];
  logic [SCORE_W-1:0] hist_b [WINDOW];
  int unsigned        box_a;
  int unsigned        box_b;
  int unsigned        rows_in_frame;
  int unsigned        peak_total;
  kind_t              peak_kind;
  int unsigned        peak_start;
  peak_report_t       peak_reports_q [$];
  int                 err_cnt;
  int                 seen_cnt;

  task automatic restart_frame();
    box_a         = 0;
    box_b         = 0;
    rows_in_frame = 0;
    peak_total    = 0;
    peak_kind     = KIND_NONE;
    peak_start    = 0;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t wspf check: %s got %0d want %0d", $time, what, got, want);
    err_cnt++;
  endtask

  // one row word: update the box sums, compete the window, report on frame end
  task automatic absorb_row(input logic [SCORE_W-1:0] a, input logic [SCORE_W-1:0] b,
                            input logic last);
    int unsigned  slot;
    int unsigned  oldest;
    peak_report_t rep;
    if (rows_in_frame < ROWS) begin
      slot         = rows_in_frame % WINDOW;
      box_a        = box_a + a;
      box_b        = box_b + b;
      hist_a[slot] = a;
      hist_b[slot] = b;
      if (rows_in_frame + 1 >= WINDOW) begin
        // A first, then B against the possibly updated best; ties keep the old
        if (box_a > peak_total) begin
          peak_total = box_a;
          peak_kind  = KIND_A;
          peak_start = rows_in_frame + 1 - WINDOW;
        end
        if (box_b > peak_total) begin
          peak_total = box_b;
          peak_kind  = KIND_B;
          peak_start = rows_in_frame + 1 - WINDOW;
        end
        oldest = (rows_in_frame + 1) % WINDOW;
        box_a  = box_a - hist_a[oldest];
        box_b  = box_b - hist_b[oldest];
      end
      rows_in_frame++;
    end
    if (last) begin
      rep.kind  = peak_kind;
      rep.start = START_W'(peak_start);
      rep.total = TOTAL_W'(peak_total);
      peak_reports_q.push_back(rep);
      restart_frame();
    end
  endtask

  task automatic check_report(input logic [OUT_DATA_W-1:0] word);
    peak_report_t want;
    kind_t        got_kind;
    logic [START_W-1:0] got_start;
    logic [TOTAL_W-1:0] got_total;
    got_kind  = word[KIND_W-1:0];
    got_start = word[KIND_W +: START_W];
    got_total = word[KIND_W+START_W +: TOTAL_W];
    if (peak_reports_q.size() == 0) begin
      report_mismatch("report word with nothing pending, total", got_total, 0);
    end else begin
      want = peak_reports_q.pop_front();
      if (got_kind !== want.kind) report_mismatch("best_kind", got_kind, want.kind);
      if (got_start !== want.start) report_mismatch("best_start", got_start, want.start);
      if (got_total !== want.total) report_mismatch("best_total", got_total, want.total);
      seen_cnt++;
    end
  endtask

  initial begin
    err_cnt  = 0;
    seen_cnt = 0;
    restart_frame();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_frame();
      peak_reports_q.delete();
    end else begin
      if (in_tvalid && in_tready)
        absorb_row(in_tdata[SCORE_W-1:0], in_tdata[SCORE_W +: SCORE_W], in_tlast);
      if (out_tvalid && out_tready)
        check_report(out_tdata);
    end
    reports_due  <= peak_reports_q.size();
    mismatches   <= err_cnt;
    reports_seen <= seen_cnt;
  end

endmodule

// ===== sim/windowed_score_peak_finder_tb.sv =====
// ----------------------------------------------------------------------------
// windowed_score_peak_finder_tb
// Streams frames of score rows into the peak finder with random gaps and
// backpressure; a checker beside the block predicts and compares each report.
// ----------------------------------------------------------------------------
module windowed_score_peak_finder_tb;
  import wspf_pkg::*;

  localparam int ROW_TARGET   = 1450;
  localparam int FRAME_TARGET = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  typedef enum int {SC_MIX, SC_TINY, SC_FLAT, SC_MAX, SC_ZERO, SC_B_UP} score_mix_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // score_a, score_b
  logic                  in_tlast   = 1'b0; // frame_end
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // best_kind, best_start, best_total

  int mismatches;
  int reports_due;
  int reports_seen;
  int rows_sent;
  int frames_sent;
  int long_frames;
  int quiet_cycles;
  bit tx_calm;
  bit rx_calm;

  always #4 clk = ~clk;

  windowed_score_peak_finder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  wspf_report_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .mismatches   (mismatches),
    .reports_due  (reports_due),
    .reports_seen (reports_seen)
  );

  // valid stays high after a word is taken; it drops only before a gap
  task automatic send_row(input logic [SCORE_W-1:0] a, input logic [SCORE_W-1:0] b,
                          input logic last);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    rows_sent++;
  endtask

  function automatic logic [SCORE_W-1:0] draw_score(input score_mix_t mix,
                                                    input logic [SCORE_W-1:0] level);
    case (mix)
      SC_TINY: return SCORE_W'($urandom_range(0, 2));
      SC_FLAT: return level;
      SC_MAX:  return SCORE_MAX;
      SC_ZERO: return '0;
      default: begin
        case ($urandom_range(0, 7))
          0:       return '0;
          1:       return SCORE_MAX;
          default: return SCORE_W'($urandom());
        endcase
      end
    endcase
  endfunction

  task automatic send_frame(input score_mix_t mix, input int len);
    logic [SCORE_W-1:0] level;
    logic [SCORE_W-1:0] a;
    logic [SCORE_W-1:0] b;
    level = SCORE_W'($urandom());
    for (int r = 0; r < len; r++) begin
      a = draw_score(mix, level);
      b = draw_score(mix, level);
      if (mix == SC_B_UP) a = SCORE_W'($urandom_range(0, 4000));
      send_row(a, b, r == len - 1);
    end
    frames_sent++;
    if (len > ROWS) long_frames++;
  endtask

  function automatic int draw_frame_len();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 5) return $urandom_range(1, WINDOW - 1);
    else if (pick < 10) return $urandom_range(WINDOW, WINDOW + 4);
    else if (pick < 18) return $urandom_range(WINDOW + 5, 60);
    else return $urandom_range(61, 100);
  endfunction

  // stop offering until every report expected so far has been taken
  task automatic drain_reports();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    rows_sent   = 0;
    frames_sent = 0;
    long_frames = 0;
    tx_calm     = 1'b0;
    rx_calm     = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-row and two-row frames at the field extremes, all short of a window
    send_row(SCORE_MAX, SCORE_MAX, 1'b1);
    send_row('0, '0, 1'b1);
    send_row(SCORE_MAX, '0, 1'b0);
    send_row('0, SCORE_MAX, 1'b1);
    frames_sent += 3;

    // fixed opening frames: full scale, all zero, flat ties, near ties,
    // B dominant, one row short of a window, and one frame past ROWS
    send_frame(SC_MAX, WINDOW);
    send_frame(SC_ZERO, WINDOW + 3);
    send_frame(SC_FLAT, WINDOW + 6);
    send_frame(SC_TINY, 45);
    send_frame(SC_B_UP, 38);
    send_frame(SC_MIX, WINDOW - 1);
    send_frame(SC_MIX, ROWS + $urandom_range(1, 20));
    drain_reports();

    while (rows_sent < ROW_TARGET || frames_sent < FRAME_TARGET) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm = ($urandom_range(0, 4) == 0);
      send_frame(score_mix_t'($urandom_range(0, 5)), draw_frame_len());
      if (frames_sent % 9 == 0) drain_reports();
    end

    drain_reports();
    repeat (8) @(posedge clk);
    $display("windowed_score_peak_finder_tb: %0d rows in %0d frames, %0d over ROWS rows",
             rows_sent, frames_sent, long_frames);
    $display("windowed_score_peak_finder_tb: %0d reports compared, %0d mismatches",
             reports_seen, mismatches);
    if (mismatches == 0) begin
      $display("windowed_score_peak_finder_tb: done, clean");
    end else begin
      $display("windowed_score_peak_finder_tb: done, errors");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off so frame ends back up
  initial begin
    int gap;
    int taken;
    bit held;
    taken = 0;
    held  = 1'b0;
    wait (rst_n);
    forever begin
      if (!held && taken >= 8) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end else begin
        gap = rx_calm ? 0 : $urandom_range(0, 9);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  // watchdog: too long without a word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t stalled, %0d reports outstanding", $time, reports_due);
      $display("windowed_score_peak_finder_tb: done, errors");
      $finish;
    end
  end

  initial quiet_cycles = 0;

endmodule
